// ===== rtl/ppoc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppoc_pkg: shared definitions for the premultiplied over compositor
// Register map codes, field widths and the lane coefficient type.
// ----------------------------------------------------------------------------
package ppoc_pkg;

    // Configuration port geometry.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int REG_IDX_W = 2;

    // Register indexes (byte address is 4 times the index).
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BLEND_MODE    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GLOBAL_ALPHA  = 2'd2;

    // Blend mode codes.
    localparam logic MODE_GLOBAL = 1'b0;
    localparam logic MODE_MASK   = 1'b1;

    // Widths of the register fields and of the blend weights.
    localparam int CNT_W   = 4;
    localparam int WGT_W   = 9;
    localparam logic [WGT_W-1:0] WGT_ONE = 9'd256;

    // Every lane computes (s * src_wgt + d * dst_wgt) >> 8.
    typedef struct packed {
        logic [WGT_W-1:0] src_wgt;
        logic [WGT_W-1:0] dst_wgt;
    } t_coef;

endpackage

// ===== rtl/ppoc_coef.sv =====
// ----------------------------------------------------------------------------
// ppoc_coef: per-word blend weights
// Works out the source and destination weights that all lanes share, from
// the source alpha byte, the mode, the global alpha and the mask byte.
// ----------------------------------------------------------------------------
module ppoc_coef (
    input  logic                        i_mode,
    input  logic [7:0]                  i_global_alpha,
    input  logic [7:0]                  i_mask,
    input  logic [7:0]                  i_src_alpha,
    output ppoc_pkg::t_coef             o_coef
);

    logic [ppoc_pkg::WGT_W-1:0] ga_exp;
    logic [ppoc_pkg::WGT_W-1:0] mask_exp;
    logic [ppoc_pkg::WGT_W-1:0] inv_sa_exp;
    logic [ppoc_pkg::WGT_W-1:0] mult_wgt;
    logic [16:0]                prod;
    logic [7:0]                 scaled_sa;
    logic [7:0]                 inv_scaled;
    logic [7:0]                 inv_sa;

    // Expand an alpha byte to the 0..256 range.
    assign ga_exp     = {1'b0, i_global_alpha} + {8'd0, i_global_alpha[7]};
    assign mask_exp   = {1'b0, i_mask} + {8'd0, i_mask[7]};
    assign inv_sa     = 8'd255 - i_src_alpha;
    assign inv_sa_exp = {1'b0, inv_sa} + {8'd0, inv_sa[7]};

    // One shared multiplier scales the source alpha by the active opacity.
    assign mult_wgt   = (i_mode == ppoc_pkg::MODE_MASK) ? mask_exp : ga_exp;
    assign prod       = {9'd0, i_src_alpha} * {8'd0, mult_wgt};
    assign scaled_sa  = prod[15:8];
    assign inv_scaled = 8'd255 - scaled_sa;

    // Pick the weights for pass, full over, blend or two-term combine.
    always_comb begin
        o_coef.src_wgt = '0;
        o_coef.dst_wgt = ppoc_pkg::WGT_ONE;
        if (i_mode == ppoc_pkg::MODE_GLOBAL) begin
            if (i_global_alpha == 8'd255) begin
                o_coef.src_wgt = ppoc_pkg::WGT_ONE;
                o_coef.dst_wgt = inv_sa_exp;
            end else if (i_global_alpha != 8'd0) begin
                o_coef.src_wgt = {1'b0, scaled_sa};
                o_coef.dst_wgt = ppoc_pkg::WGT_ONE - {1'b0, scaled_sa};
            end
        end else begin
            if (mask_exp == ppoc_pkg::WGT_ONE) begin
                o_coef.src_wgt = ppoc_pkg::WGT_ONE;
                o_coef.dst_wgt = inv_sa_exp;
            end else if (mask_exp != '0) begin
                o_coef.src_wgt = mask_exp;
                o_coef.dst_wgt = {1'b0, inv_scaled} + {8'd0, inv_scaled[7]};
            end
        end
    end

endmodule

// ===== rtl/ppoc_lane.sv =====
// ----------------------------------------------------------------------------
// ppoc_lane: one channel of the compositor
// Weighted sum of a source and a destination byte, truncated to 8 bits.
// ----------------------------------------------------------------------------
module ppoc_lane (
    input  logic [7:0]          i_src,
    input  logic [7:0]          i_dst,
    input  ppoc_pkg::t_coef     i_coef,
    output logic [7:0]          o_result
);

    logic [16:0] src_term;
    logic [16:0] dst_term;
    logic [17:0] sum;

    // Both products fit in 17 bits; the sum keeps one more.
    assign src_term = {9'd0, i_src} * {8'd0, i_coef.src_wgt};
    assign dst_term = {9'd0, i_dst} * {8'd0, i_coef.dst_wgt};
    assign sum      = {1'b0, src_term} + {1'b0, dst_term};
    assign o_result = sum[15:8];

endmodule

// ===== rtl/premult_pixel_over_compositor_top.sv =====
// ----------------------------------------------------------------------------
// premult_pixel_over_compositor_top: premultiplied source-over compositor
// Composites a source pixel over a destination pixel, one word per clock while not stalled.
//
//   channel   direction  handshake              payload
//   input     in         i_valid / o_ready      src_pixel, dst_pixel, mask, span end
//   output    out        o_valid / i_ready      out_pixel, span end
//   config    in         psel/penable/pready    paddr, pwdata, prdata
//
// A word is accepted every clock while the pipeline is not stalled. Each word is
// registered in the weight stage, then in the lane stage with the output register.
// The lane multipliers are one pair per channel. Reset is synchronous and clears
// the valid flags and the registers to channel_count 4, global mode, alpha 255.
// Each stage holds its word while the stage after it is full and stalled.
// ----------------------------------------------------------------------------
module premult_pixel_over_compositor_top #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [8*MAX_CHANNELS-1:0]       i_src_pixel,
    input  logic [8*MAX_CHANNELS-1:0]       i_dst_pixel,
    input  logic [7:0]                      i_mask_value,
    input  logic                            i_span_end,
    // Output channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [8*MAX_CHANNELS-1:0]       o_out_pixel,
    output logic                            o_span_end_out,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppoc_pkg::ADDR_W-1:0]     paddr,
    input  logic [ppoc_pkg::DATA_W-1:0]     pwdata,
    output logic [ppoc_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int PIX_W = 8 * MAX_CHANNELS;

    // Configuration registers.
    logic [ppoc_pkg::CNT_W-1:0]     r_channel_count;
    logic                           r_blend_mode;
    logic [7:0]                     r_global_alpha;
    logic [ppoc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_write;

    // Pipeline registers.
    logic                           r_v1;
    logic [PIX_W-1:0]               r_src1;
    logic [PIX_W-1:0]               r_dst1;
    logic                           r_span1;
    logic [ppoc_pkg::CNT_W-1:0]     r_n1;
    ppoc_pkg::t_coef                r_coef1;
    logic                           r_v2;
    logic [PIX_W-1:0]               r_out2;
    logic                           r_span2;

    logic                           ready2;
    logic                           accept;
    logic [ppoc_pkg::CNT_W-1:0]     n_chan;
    logic [7:0]                     src_alpha;
    ppoc_pkg::t_coef                coef;
    logic [7:0]                     lane_res [MAX_CHANNELS];
    logic [PIX_W-1:0]               n_out;

    // Register writes and reads.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ppoc_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= ppoc_pkg::CNT_W'(4);
            r_blend_mode    <= ppoc_pkg::MODE_GLOBAL;
            r_global_alpha  <= 8'd255;
        end else if (cfg_write) begin
            unique case (reg_idx)
                ppoc_pkg::REG_CHANNEL_COUNT: begin
                    r_channel_count <= pwdata[ppoc_pkg::CNT_W-1:0];
                end
                ppoc_pkg::REG_BLEND_MODE: begin
                    r_blend_mode <= pwdata[0];
                end
                ppoc_pkg::REG_GLOBAL_ALPHA: begin
                    r_global_alpha <= pwdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ppoc_pkg::REG_CHANNEL_COUNT: prdata = {28'd0, r_channel_count};
            ppoc_pkg::REG_BLEND_MODE:    prdata = {31'd0, r_blend_mode};
            ppoc_pkg::REG_GLOBAL_ALPHA:  prdata = {24'd0, r_global_alpha};
            default:                     prdata = '0;
        endcase
    end

    // Each stage takes a word when it is empty or its word moves on.
    assign ready2  = !r_v2 || i_ready;
    assign o_ready = !r_v1 || ready2;
    assign accept  = i_valid && o_ready;

    // Channels in use: zero counts as one, large counts saturate.
    always_comb begin
        if (r_channel_count == '0) begin
            n_chan = ppoc_pkg::CNT_W'(1);
        end else if (r_channel_count > ppoc_pkg::CNT_W'(MAX_CHANNELS)) begin
            n_chan = ppoc_pkg::CNT_W'(MAX_CHANNELS);
        end else begin
            n_chan = r_channel_count;
        end
    end

    // The alpha byte is the last channel in use.
    always_comb begin
        src_alpha = '0;
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            if (ppoc_pkg::CNT_W'(k + 1) == n_chan) begin
                src_alpha = i_src_pixel[8*k +: 8];
            end
        end
    end

    ppoc_coef u_coef (
        .i_mode         (r_blend_mode),
        .i_global_alpha (r_global_alpha),
        .i_mask         (i_mask_value),
        .i_src_alpha    (src_alpha),
        .o_coef         (coef)
    );

    // Weight stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src1  <= i_src_pixel;
            r_dst1  <= i_dst_pixel;
            r_span1 <= i_span_end;
            r_n1    <= n_chan;
            r_coef1 <= coef;
        end
    end

    // One lane per channel.
    for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
        ppoc_lane u_lane (
            .i_src    (r_src1[8*g +: 8]),
            .i_dst    (r_dst1[8*g +: 8]),
            .i_coef   (r_coef1),
            .o_result (lane_res[g])
        );
    end

    // Merge the lanes, zeroing channels above the count.
    always_comb begin
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            n_out[8*k +: 8] = (ppoc_pkg::CNT_W'(k) < r_n1) ? lane_res[k] : 8'd0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ready2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2 && r_v1) begin
            r_out2  <= n_out;
            r_span2 <= r_span1;
        end
    end

    assign o_valid        = r_v2;
    assign o_out_pixel    = r_out2;
    assign o_span_end_out = r_span2;

endmodule

// ===== rtl/ppoc_checker.sv =====
// ----------------------------------------------------------------------------
// ppoc_checker: port-level checks for the compositor
// Watches the top level's ports for stall, reset and latency behavior.
// ----------------------------------------------------------------------------
module ppoc_checker #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_ready,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic [8*MAX_CHANNELS-1:0]   o_out_pixel,
    input  logic                        o_span_end_out
);

    // A stalled output word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_pixel) && $stable(o_span_end_out))
        else $error("output word changed while stalled");

    // Reset leaves the output empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // With the output register empty the block always takes a word.
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    // A new output word comes from an input word accepted and passed through the weight stage register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("output word without a matching input word");

endmodule

bind premult_pixel_over_compositor_top ppoc_checker #(
    .MAX_CHANNELS (MAX_CHANNELS)
) u_ppoc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_out_pixel    (o_out_pixel),
    .o_span_end_out (o_span_end_out)
);
